FILE: hw/rtl/projective_point_transform_core_assert.svh
// ----------------------------------------------------------------------------
// projective_point_transform_core_assert
// Assertion macros shared by the projective point transform RTL.
// ----------------------------------------------------------------------------
`ifndef PROJECTIVE_POINT_TRANSFORM_CORE_ASSERT_SVH
`define PROJECTIVE_POINT_TRANSFORM_CORE_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define PPT_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define PPT_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: hw/rtl/ppt_pkg.sv
// ----------------------------------------------------------------------------
// ppt_pkg
// Shared types and constants of the projective point transform.
// ----------------------------------------------------------------------------
package ppt_pkg;

   localparam int COEF_W     = 32;
   localparam int NUM_COEF   = 16;
   localparam int NUM_PAIRS  = 8;
   localparam int PAIR_W     = 64;
   localparam int PAIR_IDX_W = 3;
   localparam int CSR_IDX_W  = 8;

   // Identity matrix in Q16.16.
   localparam logic [NUM_PAIRS-1:0][PAIR_W-1:0] COEF_RESET = {
      64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
      64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
      64'h0000_0000_0000_0000, 64'h0001_0000_0000_0000,
      64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000
   };

   // Per-word control that travels down the divider alongside the data.
   typedef struct packed {
      logic       w_zero;
      logic [2:0] neg;
      logic [2:0] ovf;
   } ctl_type;

endpackage

FILE: hw/rtl/ppt_mac.sv
// ----------------------------------------------------------------------------
// ppt_mac
// Three-stage multiply and sum: partial products, terms, row sums.
// ----------------------------------------------------------------------------
module ppt_mac #(
   parameter int COORD_WIDTH = 32,
   localparam int SW = COORD_WIDTH + ppt_pkg::COEF_W + 2
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           en,
   input  logic                                           in_valid,
   input  logic signed [COORD_WIDTH-1:0]                  x,
   input  logic signed [COORD_WIDTH-1:0]                  y,
   input  logic signed [COORD_WIDTH-1:0]                  z,
   input  logic [ppt_pkg::NUM_COEF-1:0][ppt_pkg::COEF_W-1:0] coef,
   output logic                                           out_valid,
   output logic [3:0][SW-1:0]                             sums
);
   import ppt_pkg::*;

   localparam int LO_W = COORD_WIDTH / 2;
   localparam int HI_W = COORD_WIDTH - LO_W;
   localparam int PW   = COORD_WIDTH + COEF_W;
   localparam int PLW  = LO_W + COEF_W + 1;
   localparam int PHW  = HI_W + COEF_W;

   logic signed [COORD_WIDTH-1:0] pt [3];
   logic signed [PLW-1:0]         plo_ff [4][3];
   logic signed [PHW-1:0]         phi_ff [4][3];
   logic signed [COEF_W-1:0]      off1_ff [4];
   logic signed [PW-1:0]          term_ff [4][3];
   logic signed [COEF_W-1:0]      off2_ff [4];
   logic signed [SW-1:0]          sum_ff [4];
   logic                          v1_ff, v2_ff, v3_ff;

   assign pt[0] = x;
   assign pt[1] = y;
   assign pt[2] = z;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // Each coordinate is split in two so no multiplier exceeds 32 by 32 bits.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 4; j++) begin
            for (int t = 0; t < 3; t++) begin
               plo_ff[j][t] <= PLW'($signed({1'b0, pt[t][LO_W-1:0]}))
                               * PLW'($signed(coef[4*j+t]));
               phi_ff[j][t] <= PHW'($signed(pt[t][COORD_WIDTH-1:LO_W]))
                               * PHW'($signed(coef[4*j+t]));
               term_ff[j][t] <= (PW'(phi_ff[j][t]) <<< LO_W) + PW'(plo_ff[j][t]);
            end
            off1_ff[j] <= $signed(coef[4*j+3]);
            off2_ff[j] <= off1_ff[j];
            sum_ff[j]  <= SW'(term_ff[j][0]) + SW'(term_ff[j][1]) + SW'(term_ff[j][2])
                          + SW'(off2_ff[j]);
         end
      end
   end

   assign out_valid = v3_ff;
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         sums[j] = sum_ff[j];
      end
   end

endmodule

FILE: hw/rtl/ppt_prep.sv
// ----------------------------------------------------------------------------
// ppt_prep
// Takes signs and magnitudes, flags a zero divisor and a quotient too large.
// ----------------------------------------------------------------------------
module ppt_prep #(
   parameter int COORD_WIDTH = 32,
   localparam int SW = COORD_WIDTH + ppt_pkg::COEF_W + 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [3:0][SW-1:0]    sums,
   output logic                  out_valid,
   output logic [2:0][SW-1:0]    mag,
   output logic [SW-1:0]         div,
   output ppt_pkg::ctl_type      ctl
);
   import ppt_pkg::*;

   logic [2:0][SW-1:0] a_ff, b_ff;
   logic [SW-1:0]      d_ff, e_ff;
   logic [2:0]         neg_ff;
   logic               wz_ff;
   ctl_type            ctl_ff;
   logic               va_ff, vb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else if (en) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         wz_ff <= (sums[3] == '0);
         d_ff  <= sums[3][SW-1] ? (~sums[3] + 1'b1) : sums[3];
         for (int i = 0; i < 3; i++) begin
            a_ff[i]   <= sums[i][SW-1] ? (~sums[i] + 1'b1) : sums[i];
            neg_ff[i] <= sums[i][SW-1] ^ sums[3][SW-1];
         end
         // A quotient of 2^COORD_WIDTH or more saturates for either sign.
         for (int i = 0; i < 3; i++) begin
            ctl_ff.ovf[i] <= ({{COORD_WIDTH{1'b0}}, a_ff[i]} >=
                              {d_ff, {COORD_WIDTH{1'b0}}});
         end
         ctl_ff.neg    <= neg_ff;
         ctl_ff.w_zero <= wz_ff;
         b_ff <= a_ff;
         e_ff <= d_ff;
      end
   end

   assign out_valid = vb_ff;
   assign mag       = b_ff;
   assign div       = e_ff;
   assign ctl       = ctl_ff;

endmodule

FILE: hw/rtl/ppt_div_step.sv
// ----------------------------------------------------------------------------
// ppt_div_step
// One restoring division step for three numerators sharing one divisor.
// ----------------------------------------------------------------------------
module ppt_div_step #(
   parameter int COORD_WIDTH = 32,
   parameter int SHIFT = 0,
   localparam int NW = COORD_WIDTH + ppt_pkg::COEF_W + 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [2:0][NW-1:0]           rem,
   input  logic [NW-1:0]                div,
   input  logic [2:0][COORD_WIDTH-1:0]  quo,
   input  ppt_pkg::ctl_type             ctl,
   output logic                         out_valid,
   output logic [2:0][NW-1:0]           rem_out,
   output logic [NW-1:0]                div_out,
   output logic [2:0][COORD_WIDTH-1:0]  quo_out,
   output ppt_pkg::ctl_type             ctl_out
);
   import ppt_pkg::*;

   localparam int EW = NW + COORD_WIDTH;

   logic [EW-1:0]                trial;
   logic [2:0][NW-1:0]           rem_in, rem_ff;
   logic [2:0][COORD_WIDTH-1:0]  quo_in, quo_ff;
   logic [NW-1:0]                div_ff;
   ctl_type                      ctl_ff;
   logic                         valid_ff;

   assign trial = {{COORD_WIDTH{1'b0}}, div} << SHIFT;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rem_in[i] = rem[i];
         quo_in[i] = quo[i];
         if ({{COORD_WIDTH{1'b0}}, rem[i]} >= trial) begin
            rem_in[i] = rem[i] - trial[NW-1:0];
            quo_in[i][SHIFT] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         div_ff <= div;
         ctl_ff <= ctl;
      end
   end

   assign out_valid = valid_ff;
   assign rem_out   = rem_ff;
   assign quo_out   = quo_ff;
   assign div_out   = div_ff;
   assign ctl_out   = ctl_ff;

endmodule

FILE: hw/rtl/projective_point_transform_core.sv
// ----------------------------------------------------------------------------
// projective_point_transform_core
// Applies a 4x4 homogeneous Q16.16 matrix to a point and divides by w.
// ----------------------------------------------------------------------------
// A point can enter every cycle while the pipeline is not held. It passes
// through multiply and sum, sign handling and range check, one restoring
// division step per quotient bit (three rows in parallel against the
// shared w), and saturation into the output register. The whole pipeline
// holds while a result word waits on rsp_stall. Coefficients are to be
// loaded through the csr port while the block is idle; the user is bound
// by this; the block does not enforce it. Indexes beyond seven are ignored.
module projective_point_transform_core #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [COORD_WIDTH-1:0]       req_x_in,
   input  logic signed [COORD_WIDTH-1:0]       req_y_in,
   input  logic signed [COORD_WIDTH-1:0]       req_z_in,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [COORD_WIDTH-1:0]       rsp_x_out,
   output logic signed [COORD_WIDTH-1:0]       rsp_y_out,
   output logic signed [COORD_WIDTH-1:0]       rsp_z_out,
   output logic                                rsp_w_zero,
   output logic                                rsp_clipped,
   input  logic                                csr_wr_en,
   input  logic [ppt_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ppt_pkg::PAIR_W-1:0]          csr_wr_data
);
   import ppt_pkg::*;

   localparam int NW = COORD_WIDTH + COEF_W + 2;
   localparam logic [COORD_WIDTH-1:0] MAX_POS = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic [COORD_WIDTH-1:0] MIN_NEG = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   logic [NUM_PAIRS-1:0][PAIR_W-1:0]   coef_ff;
   logic [NUM_COEF-1:0][COEF_W-1:0]    coef_words;
   logic                               advance;
   logic                               mac_valid, prep_valid;
   logic [3:0][NW-1:0]                 sums;

   logic                               v_s   [COORD_WIDTH+1];
   logic [2:0][NW-1:0]                 rem_s [COORD_WIDTH+1];
   logic [NW-1:0]                      div_s [COORD_WIDTH+1];
   logic [2:0][COORD_WIDTH-1:0]        quo_s [COORD_WIDTH+1];
   ctl_type                            ctl_s [COORD_WIDTH+1];

   logic [2:0][COORD_WIDTH-1:0]        res_in, res_ff;
   logic [2:0]                         clip_in;
   logic                               w_zero_ff, clipped_ff, rsp_valid_ff;
   ctl_type                            fin;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= COEF_RESET;
      end else if (csr_wr_en && (csr_index < CSR_IDX_W'(NUM_PAIRS))) begin
         coef_ff[csr_index[PAIR_IDX_W-1:0]] <= csr_wr_data;
      end
   end
   assign coef_words = coef_ff;

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   ppt_mac #(.COORD_WIDTH(COORD_WIDTH)) u_mac (
      .clock(clock), .reset(reset), .en(advance), .in_valid(req_valid),
      .x(req_x_in), .y(req_y_in), .z(req_z_in), .coef(coef_words),
      .out_valid(mac_valid), .sums(sums)
   );

   ppt_prep #(.COORD_WIDTH(COORD_WIDTH)) u_prep (
      .clock(clock), .reset(reset), .en(advance), .in_valid(mac_valid),
      .sums(sums), .out_valid(prep_valid), .mag(rem_s[0]), .div(div_s[0]),
      .ctl(ctl_s[0])
   );
   assign v_s[0]   = prep_valid;
   assign quo_s[0] = '0;

   // Stage k resolves quotient bit COORD_WIDTH-1-k.
   for (genvar k = 0; k < COORD_WIDTH; k++) begin : g_div
      ppt_div_step #(.COORD_WIDTH(COORD_WIDTH), .SHIFT(COORD_WIDTH-1-k)) u_step (
         .clock(clock), .reset(reset), .en(advance), .in_valid(v_s[k]),
         .rem(rem_s[k]), .div(div_s[k]), .quo(quo_s[k]), .ctl(ctl_s[k]),
         .out_valid(v_s[k+1]), .rem_out(rem_s[k+1]), .div_out(div_s[k+1]),
         .quo_out(quo_s[k+1]), .ctl_out(ctl_s[k+1])
      );
   end

   assign fin = ctl_s[COORD_WIDTH];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         clip_in[i] = 1'b0;
         if (fin.ovf[i]) begin
            clip_in[i] = 1'b1;
            res_in[i]  = fin.neg[i] ? MIN_NEG : MAX_POS;
         end else if (fin.neg[i]) begin
            if (quo_s[COORD_WIDTH][i] > MIN_NEG) begin
               clip_in[i] = 1'b1;
               res_in[i]  = MIN_NEG;
            end else begin
               res_in[i]  = ~quo_s[COORD_WIDTH][i] + 1'b1;
            end
         end else begin
            if (quo_s[COORD_WIDTH][i] > MAX_POS) begin
               clip_in[i] = 1'b1;
               res_in[i]  = MAX_POS;
            end else begin
               res_in[i]  = quo_s[COORD_WIDTH][i];
            end
         end
         if (fin.w_zero) begin
            clip_in[i] = 1'b0;
            res_in[i]  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= v_s[COORD_WIDTH];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_ff     <= res_in;
         w_zero_ff  <= fin.w_zero;
         clipped_ff <= |clip_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_x_out   = res_ff[0];
   assign rsp_y_out   = res_ff[1];
   assign rsp_z_out   = res_ff[2];
   assign rsp_w_zero  = w_zero_ff;
   assign rsp_clipped = clipped_ff;

`include "projective_point_transform_core_assert.svh"

   `PPT_ASSERT_IMPLY(a_wzero_clean, rsp_valid && rsp_w_zero,
      !rsp_clipped && rsp_x_out == '0 && rsp_y_out == '0 && rsp_z_out == '0)
   `PPT_ASSERT_IMPLY(a_clip_extreme, rsp_valid && rsp_clipped,
      rsp_x_out == MAX_POS || rsp_x_out == MIN_NEG || rsp_y_out == MAX_POS ||
      rsp_y_out == MIN_NEG || rsp_z_out == MAX_POS || rsp_z_out == MIN_NEG)
   `PPT_ASSERT_NEXT(a_hold_on_stall, rsp_valid && rsp_stall,
      rsp_valid && $stable(res_ff) && $stable(v_s[COORD_WIDTH]))

endmodule
